// ----- sv/jmr_pkg.sv -----
package jmr_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_CALM_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALM_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_BTN = 3'd6;

    // Register reset values
    localparam logic [23:0] CALM_LOW_RST  = 24'd39322;
    localparam logic [23:0] CALM_HIGH_RST = 24'd147456;
    localparam logic [6:0]  DEAD_RST      = 7'd13;
    localparam logic [7:0]  GAIN_RST      = 8'd16;

    // Shake button select codes
    localparam logic [1:0] SB_LEFT   = 2'd0;
    localparam logic [1:0] SB_RIGHT  = 2'd1;
    localparam logic [1:0] SB_MIDDLE = 2'd2;
    localparam logic [1:0] SB_OFF    = 2'd3;

    // Mouse button masks
    localparam logic [2:0] BTN_LEFT   = 3'b001;
    localparam logic [2:0] BTN_RIGHT  = 3'b010;
    localparam logic [2:0] BTN_MIDDLE = 3'b100;

    // Detector countdown defaults
    localparam int STARTUP_TICKS_DEF = 5;
    localparam int PERSIST_TICKS_DEF = 20;

endpackage

// ----- sv/joystick_mouse_report_with_shake.sv -----
// Turns one controller sample (three accelerations, two stick axes, two
// buttons) into one mouse report. From input transfer to a valid report, a
// sample passes the first register, holding the acceleration squares and the
// stick-times-gain products, and then the second (the output register),
// holding the finished report; one sample is taken every cycle while
// the output side does not stall. The shake detector advances once per report
// as it enters the output register, so its countdowns count samples, not clock
// cycles. The configuration port is always ready; write registers only while
// no sample is in flight.
module joystick_mouse_report_with_shake #(
    parameter int unsigned STARTUP_TICKS = jmr_pkg::STARTUP_TICKS_DEF,
    parameter int unsigned PERSIST_TICKS = jmr_pkg::PERSIST_TICKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [jmr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jmr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [11:0]             i_accel_x,
    input  logic signed [11:0]             i_accel_y,
    input  logic signed [11:0]             i_accel_z,
    input  logic signed [7:0]              i_stick_x,
    input  logic signed [7:0]              i_stick_y,
    input  logic                           i_button_c,
    input  logic                           i_button_z,
    // report channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_button_bits,
    output logic signed [7:0]              o_move_x,
    output logic signed [7:0]              o_move_y,
    output logic                           o_shake_active
);
    import jmr_pkg::*;

    localparam logic [7:0] START_LOAD   = 8'(STARTUP_TICKS);
    localparam logic [7:0] PERSIST_LOAD = 8'(PERSIST_TICKS);

    // configuration registers
    logic [23:0] r_calm_low;
    logic [23:0] r_calm_high;
    logic [6:0]  r_dead_x;
    logic [6:0]  r_dead_y;
    logic [7:0]  r_gain_x;
    logic [7:0]  r_gain_y;
    logic [1:0]  r_shake_btn;

    // first stage
    logic        r_s1_valid;
    logic [22:0] r_sq_x;
    logic [22:0] r_sq_y;
    logic [22:0] r_sq_z;
    logic [14:0] r_prod_x;
    logic [14:0] r_prod_y;
    logic        r_neg_x;
    logic        r_neg_y;
    logic        r_dead_hit_x;
    logic        r_dead_hit_y;
    logic [1:0]  r_btn;

    // detector state
    logic [7:0]  r_start_count;
    logic [7:0]  r_persist_count;
    logic        r_shaking;
    logic [7:0]  n_start_count;
    logic [7:0]  n_persist_count;
    logic        n_shaking;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_button_bits;
    logic [7:0]  r_move_x;
    logic [7:0]  r_move_y;
    logic        r_shake_active;

    logic        out_take;
    logic        s1_take;
    logic        in_xfer;
    logic        s1_xfer;

    logic signed [23:0] sq_full_x;
    logic signed [23:0] sq_full_y;
    logic signed [23:0] sq_full_z;
    logic [7:0]  mag_x;
    logic [7:0]  mag_y;
    logic [15:0] prod_full_x;
    logic [15:0] prod_full_y;

    logic [23:0] sq_sum;
    logic        shake;
    logic        active;
    logic [2:0]  n_button_bits;
    logic [7:0]  n_move_x;
    logic [7:0]  n_move_y;

    // Saturate a scaled magnitude to a signed byte, applying the sign; a dead-zone hit gives zero
    function automatic logic [7:0] sat_axis(input logic [14:0] prod, input logic neg,
                                            input logic dead);
        logic [10:0] s;
        logic [7:0]  r;
        s = prod[14:4];
        if (dead) begin
            r = 8'd0;
        end else if (neg) begin
            r = (s > 11'd128) ? 8'h80 : 8'(~s + 11'd1);
        end else begin
            r = (s > 11'd127) ? 8'h7F : s[7:0];
        end
        return r;
    endfunction

    // handshake: output register frees first, first stage follows
    assign out_take   = !r_out_valid || !i_out_stall;
    assign s1_take    = !r_s1_valid || out_take;
    assign o_in_stall = !s1_take;
    assign in_xfer    = i_in_valid && s1_take;
    assign s1_xfer    = r_s1_valid && out_take;
    assign o_cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calm_low  <= CALM_LOW_RST;
            r_calm_high <= CALM_HIGH_RST;
            r_dead_x    <= DEAD_RST;
            r_dead_y    <= DEAD_RST;
            r_gain_x    <= GAIN_RST;
            r_gain_y    <= GAIN_RST;
            r_shake_btn <= SB_RIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CALM_LOW:  r_calm_low  <= i_cfg_data;
                CFG_CALM_HIGH: r_calm_high <= i_cfg_data;
                CFG_DEAD_X:    r_dead_x    <= i_cfg_data[6:0];
                CFG_DEAD_Y:    r_dead_y    <= i_cfg_data[6:0];
                CFG_GAIN_X:    r_gain_x    <= i_cfg_data[7:0];
                CFG_GAIN_Y:    r_gain_y    <= i_cfg_data[7:0];
                CFG_SHAKE_BTN: r_shake_btn <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // square accelerations, take stick magnitudes times gain
    always_comb begin
        sq_full_x   = i_accel_x * i_accel_x;
        sq_full_y   = i_accel_y * i_accel_y;
        sq_full_z   = i_accel_z * i_accel_z;
        mag_x       = i_stick_x[7] ? (~i_stick_x + 8'd1) : i_stick_x;
        mag_y       = i_stick_y[7] ? (~i_stick_y + 8'd1) : i_stick_y;
        prod_full_x = mag_x * r_gain_x;
        prod_full_y = mag_y * r_gain_y;
    end

    // first stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_take) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // first stage payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sq_x       <= sq_full_x[22:0];
            r_sq_y       <= sq_full_y[22:0];
            r_sq_z       <= sq_full_z[22:0];
            r_prod_x     <= prod_full_x[14:0];
            r_prod_y     <= prod_full_y[14:0];
            // Y is negated, so a positive stick gives a negative move
            r_neg_x      <= i_stick_x[7];
            r_neg_y      <= !i_stick_y[7];
            r_dead_hit_x <= mag_x < {1'b0, r_dead_x};
            r_dead_hit_y <= mag_y < {1'b0, r_dead_y};
            r_btn        <= {i_button_z, i_button_c};
        end
    end

    // band test and detector update
    always_comb begin
        sq_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y} + {1'b0, r_sq_z};
        shake  = (sq_sum > r_calm_high) || (sq_sum < r_calm_low);

        n_start_count   = r_start_count;
        n_persist_count = r_persist_count;
        n_shaking       = r_shaking;
        active          = 1'b0;

        if (r_shake_btn != SB_OFF) begin
            if (shake) begin
                if (r_shaking) begin
                    n_persist_count = PERSIST_LOAD;
                    active          = 1'b1;
                end else if (r_start_count == 8'd0) begin
                    n_start_count   = START_LOAD;
                    n_shaking       = 1'b1;
                    n_persist_count = PERSIST_LOAD;
                    active          = 1'b1;
                end else begin
                    n_start_count = r_start_count - 8'd1;
                end
            end else if (r_persist_count <= 8'd1) begin
                n_persist_count = 8'd0;
                n_shaking       = 1'b0;
            end else begin
                n_persist_count = r_persist_count - 8'd1;
                active          = 1'b1;
            end
        end

        // assemble buttons: C left, Z right, plus shake button
        n_button_bits = {1'b0, r_btn};
        if (active) begin
            case (r_shake_btn)
                SB_LEFT:   n_button_bits = n_button_bits | BTN_LEFT;
                SB_RIGHT:  n_button_bits = n_button_bits | BTN_RIGHT;
                default:   n_button_bits = n_button_bits | BTN_MIDDLE;
            endcase
        end

        n_move_x = sat_axis(r_prod_x, r_neg_x, r_dead_hit_x);
        n_move_y = sat_axis(r_prod_y, r_neg_y, r_dead_hit_y);
    end

    // advance detector state once per report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_count   <= START_LOAD;
            r_persist_count <= 8'd0;
            r_shaking       <= 1'b0;
        end else if (s1_xfer) begin
            r_start_count   <= n_start_count;
            r_persist_count <= n_persist_count;
            r_shaking       <= n_shaking;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_xfer) begin
            r_button_bits  <= n_button_bits;
            r_move_x       <= n_move_x;
            r_move_y       <= n_move_y;
            r_shake_active <= active;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_button_bits  = r_button_bits;
    assign o_move_x       = r_move_x;
    assign o_move_y       = r_move_y;
    assign o_shake_active = r_shake_active;

endmodule

// ----- sv/jmr_checker.sv -----
module jmr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [2:0]        o_button_bits,
    input logic signed [7:0] o_move_x,
    input logic signed [7:0] o_move_y,
    input logic              o_shake_active
);

    // no report is offered right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("report valid after reset");

    // a shaking report always carries some button
    a_shake_has_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_shake_active) |-> (o_button_bits != 3'b000))
        else $error("shake active without a button bit");

    // a stalled report holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_button_bits)
            && $stable(o_move_x) && $stable(o_move_y) && $stable(o_shake_active)))
        else $error("stalled report changed");

    // a transferred sample reaches the output when the output side does not stall meanwhile
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("report missing two cycles after transfer");

endmodule

bind joystick_mouse_report_with_shake jmr_checker u_jmr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_button_bits  (o_button_bits),
    .o_move_x       (o_move_x),
    .o_move_y       (o_move_y),
    .o_shake_active (o_shake_active)
);
